// ===== rtl/core/kbr_pkg.sv =====
package kbr_pkg;

	// Stream payload widths (fields packed from bit 0, padded to whole bytes)
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_W       = 2;

	// Item kind carried on s_tuser
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_LOAD   = 1'b1;

	typedef enum logic [1:0] {
		KIND_LITERAL  = 2'd0,
		KIND_LAYER    = 2'd1,
		KIND_MODIFIER = 2'd2,
		KIND_INERT    = 2'd3
	} kind_e;

	// One keymap entry as stored in the keymap and the latched-entry RAMs
	typedef struct packed {
		kind_e       kind;
		logic [7:0]  value;
	} entry_t;

	// Slot list update request
	typedef struct packed {
		logic push;
		logic pop;
	} slot_cmd_t;

endpackage

// ===== rtl/core/keyboard_matrix_hid_report_builder_core.sv =====
// First report byte: a scan-ending request is registered into stage 1, and its report is captured when stage 1 fires.
// Throughput: one request per cycle unless stage 1 holds a waiting report; a report is SLOTS+2 bytes on the output.
// A scan-ending request that needs a report waits in stage 1 while the previous report drains.
// The keymap read (one RAM port, registered) and the state update form a two-stage pipeline.
// Reset (arst_n low, asynchronous) clears key levels, slot count, modifiers, layers and report
// state; keymap and latched-entry RAMs are not cleared and need no clearing pass.
module keyboard_matrix_hid_report_builder_core #(
	parameter int ROWS   = 8,
	parameter int COLS   = 16,
	parameter int LAYERS = 4,
	parameter int SLOTS  = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: home_layer
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kbr_pkg::CFG_W-1:0]        cfg_data,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// row[2:0] col[6:3] pressed[7] load_layer[9:8] entry_kind[11:10] entry_value[19:12]
	input  logic [kbr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,   // action
	input  logic                             s_tlast,   // scan_end
	// report byte stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// byte_index[2:0] report_byte[10:3]
	output logic [kbr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast    // last
);

	import kbr_pkg::*;

	localparam int KEYS    = ROWS * COLS;
	localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int MAP_D   = LAYERS * KEYS;
	localparam int MAP_W   = (MAP_D > 1) ? $clog2(MAP_D) : 1;
	localparam int TOTAL   = SLOTS + 2;
	localparam int IDX_W   = $clog2(TOTAL);
	localparam int ENT_W   = $bits(entry_t);

	function automatic logic [LAYER_W-1:0] clamp_layer(input logic [7:0] v);
		logic [LAYER_W-1:0] r;
		if (32'(v) >= LAYERS) begin
			r = LAYER_W'(LAYERS - 1);
		end else begin
			r = LAYER_W'(v);
		end
		return r;
	endfunction

	// request fields
	logic [2:0]       in_row;
	logic [3:0]       in_col;
	logic             in_pressed;
	logic [1:0]       in_load_layer;
	entry_t           in_entry;
	logic             in_range;
	logic [KEY_W-1:0] in_key;
	logic             in_accept;

	// stage 1
	logic             valid_s1;
	logic             act_s1;
	logic             range_s1;
	logic [KEY_W-1:0] key_s1;
	logic             pressed_s1;
	logic             scan_end_s1;
	logic             load_ok_s1;
	logic [MAP_W-1:0] map_waddr_s1;
	entry_t           load_entry_s1;
	logic             map_byp_s1;
	entry_t           map_byp_data_s1;
	logic             lat_byp_s1;
	entry_t           lat_byp_data_s1;

	// block state
	logic [1:0]         home_layer_q;
	logic [KEYS-1:0]    key_down_q;
	logic [7:0]         mod_q;
	logic [7:0]         mod_d;
	logic [LAYER_W-1:0] layer_q;
	logic [LAYER_W-1:0] layer_d;
	logic               scan_changed_q;

	// RAM ports
	logic [MAP_W-1:0] map_raddr;
	logic [ENT_W-1:0] map_rdata;
	logic             map_we;
	logic [ENT_W-1:0] lat_rdata;
	logic             lat_we;

	// stage 1 decode
	entry_t           map_entry;
	entry_t           lat_entry;
	entry_t           ent;
	logic             is_sample;
	logic             kd;
	logic             do_press;
	logic             do_release;
	logic             changed_any;
	logic             report_req;
	logic             fire_s1;
	slot_cmd_t        slot_cmd;
	logic [SLOTS-1:0][7:0] codes_d;

	// report output
	logic                  busy_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TOTAL-1:0][7:0] rep_q;
	logic                  out_accept;
	logic                  idx_last;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_layer_q <= '0;
		end else if (cfg_valid) begin
			home_layer_q <= cfg_data;
		end
	end

	// unpack the request
	assign in_row        = s_tdata[2:0];
	assign in_col        = s_tdata[6:3];
	assign in_pressed    = s_tdata[7];
	assign in_load_layer = s_tdata[9:8];
	assign in_entry      = entry_t'({s_tdata[11:10], s_tdata[19:12]});
	assign in_range      = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
	assign in_key        = KEY_W'(32'(in_row) * COLS + 32'(in_col));
	assign in_accept     = s_tvalid && s_tready;

	// keymap read uses the layer as stage 1 leaves it
	assign map_raddr = MAP_W'(32'(layer_d) * KEYS + 32'(in_key));

	// stage 1 advances unless its report must wait for the output
	assign fire_s1  = valid_s1 && !(report_req && busy_q);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// stage 1 payload, with forwarding of the write stage 1 does this cycle
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_s1          <= s_tuser;
			range_s1        <= in_range;
			key_s1          <= in_key;
			pressed_s1      <= in_pressed;
			scan_end_s1     <= s_tlast;
			load_ok_s1      <= in_range && (32'(in_load_layer) < LAYERS);
			map_waddr_s1    <= MAP_W'(32'(in_load_layer) * KEYS + 32'(in_key));
			load_entry_s1   <= in_entry;
			map_byp_s1      <= map_we && (map_waddr_s1 == map_raddr);
			map_byp_data_s1 <= load_entry_s1;
			lat_byp_s1      <= lat_we && (key_s1 == in_key);
			lat_byp_data_s1 <= map_entry;
		end
	end

	kbr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAP_D)
	) u_keymap (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr_s1),
		.wdata (load_entry_s1),
		.re    (in_accept),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	kbr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (KEYS)
	) u_latched (
		.clk   (clk),
		.we    (lat_we),
		.waddr (key_s1),
		.wdata (map_entry),
		.re    (in_accept),
		.raddr (in_key),
		.rdata (lat_rdata)
	);

	// stage 1 decode of the key event
	assign map_entry  = map_byp_s1 ? map_byp_data_s1 : entry_t'(map_rdata);
	assign lat_entry  = lat_byp_s1 ? lat_byp_data_s1 : entry_t'(lat_rdata);
	assign is_sample  = valid_s1 && (act_s1 == ACT_SAMPLE);
	assign kd         = key_down_q[key_s1];
	assign do_press   = is_sample && range_s1 && pressed_s1 && !kd;
	assign do_release = is_sample && range_s1 && !pressed_s1 && kd;
	assign ent        = do_press ? map_entry : lat_entry;
	assign changed_any = scan_changed_q || do_press || do_release;
	assign report_req = is_sample && scan_end_s1 && changed_any;

	assign map_we = fire_s1 && (act_s1 == ACT_LOAD) && load_ok_s1;
	assign lat_we = fire_s1 && do_press;

	// layer, modifier and slot-list next state
	always_comb begin
		layer_d       = layer_q;
		mod_d         = mod_q;
		slot_cmd.push = 1'b0;
		slot_cmd.pop  = 1'b0;
		if (fire_s1 && (do_press || do_release)) begin
			unique case (ent.kind)
				KIND_LITERAL: begin
					slot_cmd.push = do_press;
					slot_cmd.pop  = do_release;
				end
				KIND_LAYER: begin
					layer_d = do_press ? clamp_layer(ent.value) : clamp_layer({6'd0, home_layer_q});
				end
				KIND_MODIFIER: begin
					mod_d = do_press ? (mod_q | ent.value) : (mod_q ^ ent.value);
				end
				KIND_INERT: begin
				end
				default: begin
				end
			endcase
		end
	end

	kbr_slots #(
		.SLOTS (SLOTS),
		.KEY_W (KEY_W)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (slot_cmd),
		.key     (key_s1),
		.code    (ent.value),
		.codes_d (codes_d)
	);

	// key levels, layer, modifiers, change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q     <= '0;
			layer_q        <= '0;
			mod_q          <= '0;
			scan_changed_q <= 1'b0;
		end else begin
			layer_q <= layer_d;
			mod_q   <= mod_d;
			if (fire_s1 && do_press) begin
				key_down_q[key_s1] <= 1'b1;
			end else if (fire_s1 && do_release) begin
				key_down_q[key_s1] <= 1'b0;
			end
			if (fire_s1 && is_sample) begin
				scan_changed_q <= report_req ? 1'b0 : changed_any;
			end
		end
	end

	// report buffer: snapshot then shift one byte out per transfer
	assign out_accept = busy_q && m_tready;
	assign idx_last   = (idx_q == IDX_W'(TOTAL - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (fire_s1 && report_req) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_accept) begin
			busy_q <= !idx_last;
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && report_req) begin
			rep_q <= {codes_d, 8'h00, mod_d};
		end else if (out_accept) begin
			rep_q <= {8'h00, rep_q[TOTAL-1:1]};
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = idx_last;
	assign m_tdata  = {5'd0, rep_q[0], 3'(idx_q)};

endmodule

// ===== rtl/core/kbr_ram.sv =====
module kbr_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read that holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/kbr_slots.sv =====
module kbr_slots #(
	parameter int SLOTS = 6,
	parameter int KEY_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kbr_pkg::slot_cmd_t         cmd,
	input  logic [KEY_W-1:0]           key,
	input  logic [7:0]                 code,
	output logic [SLOTS-1:0][7:0]      codes_d
);

	import kbr_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [KEY_W-1:0] owner_q [SLOTS];
	logic [7:0]       code_q  [SLOTS];
	logic [KEY_W-1:0] owner_d [SLOTS];
	logic [7:0]       code_d  [SLOTS];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] shift;
	logic             push_ok;
	logic             pop_ok;

	// push only while a slot is free, pop only when the key owns a slot
	assign push_ok = cmd.push && (count_q < CNT_W'(SLOTS));
	assign pop_ok  = cmd.pop && (|match);

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	for (genvar j = 0; j < SLOTS; j++) begin : g_slot
		logic [KEY_W-1:0] up_owner;
		logic [7:0]       up_code;

		// neighbor above closes the gap on a release
		if (j < SLOTS - 1) begin : g_up
			assign up_owner = owner_q[j+1];
			assign up_code  = code_q[j+1];
		end else begin : g_top
			assign up_owner = owner_q[j];
			assign up_code  = code_q[j];
		end

		assign match[j] = (CNT_W'(j) < count_q) && (owner_q[j] == key);
		assign shift[j] = |match[j:0];

		always_comb begin
			owner_d[j] = owner_q[j];
			code_d[j]  = code_q[j];
			if (push_ok && (count_q == CNT_W'(j))) begin
				owner_d[j] = key;
				code_d[j]  = code;
			end else if (pop_ok && shift[j]) begin
				owner_d[j] = up_owner;
				code_d[j]  = up_code;
			end
		end

		// unused slots read as zero in the report
		assign codes_d[j] = (CNT_W'(j) < count_d) ? code_d[j] : 8'h00;
	end

	always_ff @(posedge clk) begin
		owner_q <= owner_d;
		code_q  <= code_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/core/kbr_sva.sv =====
module kbr_sva #(
	parameter int SLOTS = 6
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [kbr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                             m_tlast
);

	// stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("report byte changed while stalled");

	// bytes of a report come back to back with rising index
	a_out_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
		else $error("report byte sequence broken");

	// reserved byte is zero
	a_reserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == 3'd1) |-> (m_tdata[10:3] == 8'h00))
		else $error("reserved report byte not zero");

	// last marks the final slot byte
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[2:0] == 3'(SLOTS + 1)))
		else $error("last on wrong byte");

endmodule

bind keyboard_matrix_hid_report_builder_core kbr_sva #(
	.SLOTS (SLOTS)
) u_kbr_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
